// ===== src/mwm_pkg.sv =====
// Shared widths, reset values, register map and payload types for the mecanum wheel mixer.
package mwm_pkg;

    localparam int NWHEEL    = 4;
    localparam int IN_W      = 16;
    localparam int LIM_W     = 15;
    localparam int RATIO_W   = 24;
    localparam int ROT_W     = 41;
    localparam int LIN_W     = 18;
    localparam int FRAC_SH   = 16;
    localparam int MAG_W     = 40;
    localparam int HALF_W    = 20;
    localparam int PP_W      = HALF_W + RATIO_W;
    localparam int RPM_W     = 24;
    localparam int ABS_W     = 16;
    localparam int QUO_W     = 15;
    localparam int NUM_W     = ABS_W + LIM_W;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam int FRONT_STAGES = 4;
    localparam int RPM_STAGES   = 4;

    localparam logic [LIM_W-1:0]   RST_MAX_FORWARD  = 15'd3500;
    localparam logic [LIM_W-1:0]   RST_MAX_SIDEWAYS = 15'd3500;
    localparam logic [LIM_W-1:0]   RST_MAX_TURN     = 15'd300;
    localparam logic [RATIO_W-1:0] RST_ROTATE_RATIO = 24'd600000;
    localparam logic [RATIO_W-1:0] RST_RPM_RATIO    = 24'd110900;
    localparam logic [LIM_W-1:0]   RST_MAX_WHEEL    = 15'd8500;

    typedef enum logic [2:0] {
        REG_MAX_FORWARD  = 3'd0,
        REG_MAX_SIDEWAYS = 3'd1,
        REG_MAX_TURN     = 3'd2,
        REG_ROTATE_RATIO = 3'd3,
        REG_RPM_RATIO    = 3'd4,
        REG_MAX_WHEEL    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [IN_W-1:0] vx;
        logic signed [IN_W-1:0] vy;
        logic signed [IN_W-1:0] vw;
    } t_cmd;

    typedef struct packed {
        logic [NWHEEL-1:0]            neg;
        logic [NWHEEL-1:0][MAG_W-1:0] mag;
    } t_mag;

    typedef struct packed {
        logic [NWHEEL-1:0][ABS_W-1:0] w;
        logic [NWHEEL-1:0][NUM_W-1:0] rem;
        logic [NWHEEL-1:0][QUO_W-1:0] quo;
        logic [ABS_W-1:0]             peak;
        logic                         scaled;
    } t_div;

endpackage

// ===== src/mecanum_wheel_speed_mixer.sv =====
// Top level of the mecanum wheel speed mixer: register port, pipeline and output stage.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one chassis velocity request per
//   cycle while o_stall is low: forward, leftward and turn rate. Output channel
//   (o_valid / i_stall) returns four wheel rpm values and a flag that proportional
//   scaling was applied. Registers are written over the APB port (byte address
//   4*index, pready always high); the user must write them only while no request
//   is in flight; the block does not enforce it. Reads return the stored value.
// Pipeline: 24 register stages (4 clamp/mix stages, 4 rpm and peak stages, 15 divider
//   stages at one quotient bit each, one output register).
// Throughput: one request per cycle unless stalled, set by the fully pipelined divider.
// Reset: synchronous, active low; clears every valid bit and loads the register
//   defaults. Payload registers are not reset.
// Receiver stall: the output register holds; each upstream stage keeps moving
//   into empty slots, so bubbles close up and o_stall rises only once every
//   stage holds a request.
module mecanum_wheel_speed_mixer
    import mwm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [IN_W-1:0] i_forward_speed,
    input  logic signed [IN_W-1:0] i_sideways_speed,
    input  logic signed [IN_W-1:0] i_turn_rate,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [IN_W-1:0] o_front_right_rpm,
    output logic signed [IN_W-1:0] o_front_left_rpm,
    output logic signed [IN_W-1:0] o_back_left_rpm,
    output logic signed [IN_W-1:0] o_back_right_rpm,
    output logic                   o_was_scaled
);

    localparam int PIPE_DEPTH = FRONT_STAGES + RPM_STAGES + QUO_W + 1;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    logic [LIM_W-1:0]   r_max_forward;
    logic [LIM_W-1:0]   r_max_sideways;
    logic [LIM_W-1:0]   r_max_turn;
    logic [RATIO_W-1:0] r_rotate_ratio;
    logic [RATIO_W-1:0] r_rpm_ratio;
    logic [LIM_W-1:0]   r_max_wheel;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    t_cmd in_cmd;
    logic front_ready, front_valid;
    t_mag front_mag;
    logic rpm_ready;

    logic div_valid [QUO_W+1];
    logic div_ready [QUO_W+1];
    t_div div_data  [QUO_W+1];

    logic             out_en;
    logic             r_out_v;
    logic [IN_W-1:0]  r_rpm [NWHEEL];
    logic [IN_W-1:0]  n_rpm [NWHEEL];
    logic             r_scaled;

    logic             in_acc, out_acc;
    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_forward  <= RST_MAX_FORWARD;
            r_max_sideways <= RST_MAX_SIDEWAYS;
            r_max_turn     <= RST_MAX_TURN;
            r_rotate_ratio <= RST_ROTATE_RATIO;
            r_rpm_ratio    <= RST_RPM_RATIO;
            r_max_wheel    <= RST_MAX_WHEEL;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MAX_FORWARD:  r_max_forward  <= pwdata[LIM_W-1:0];
                REG_MAX_SIDEWAYS: r_max_sideways <= pwdata[LIM_W-1:0];
                REG_MAX_TURN:     r_max_turn     <= pwdata[LIM_W-1:0];
                REG_ROTATE_RATIO: r_rotate_ratio <= pwdata[RATIO_W-1:0];
                REG_RPM_RATIO:    r_rpm_ratio    <= pwdata[RATIO_W-1:0];
                REG_MAX_WHEEL:    r_max_wheel    <= pwdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MAX_FORWARD:  prdata = DATA_W'(r_max_forward);
            REG_MAX_SIDEWAYS: prdata = DATA_W'(r_max_sideways);
            REG_MAX_TURN:     prdata = DATA_W'(r_max_turn);
            REG_ROTATE_RATIO: prdata = DATA_W'(r_rotate_ratio);
            REG_RPM_RATIO:    prdata = DATA_W'(r_rpm_ratio);
            REG_MAX_WHEEL:    prdata = DATA_W'(r_max_wheel);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        in_cmd.vx = i_forward_speed;
        in_cmd.vy = i_sideways_speed;
        in_cmd.vw = i_turn_rate;
    end

    assign o_stall = !front_ready;

    mwm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (front_ready),
        .i_cmd          (in_cmd),
        .i_max_forward  (r_max_forward),
        .i_max_sideways (r_max_sideways),
        .i_max_turn     (r_max_turn),
        .i_rotate_ratio (r_rotate_ratio),
        .o_valid        (front_valid),
        .i_ready        (rpm_ready),
        .o_mag          (front_mag)
    );

    mwm_rpm u_rpm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (front_valid),
        .o_ready     (rpm_ready),
        .i_mag       (front_mag),
        .i_rpm_ratio (r_rpm_ratio),
        .i_max_wheel (r_max_wheel),
        .o_valid     (div_valid[0]),
        .i_ready     (div_ready[0]),
        .o_div       (div_data[0])
    );

    for (genvar gi = 0; gi < QUO_W; gi++) begin : g_div
        mwm_div_step #(
            .BIT (QUO_W - 1 - gi)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[gi]),
            .o_ready (div_ready[gi]),
            .i_div   (div_data[gi]),
            .o_valid (div_valid[gi+1]),
            .i_ready (div_ready[gi+1]),
            .o_div   (div_data[gi+1])
        );
    end

    assign out_en            = !r_out_v || !i_stall;
    assign div_ready[QUO_W]  = out_en;

    always_comb begin
        for (int i = 0; i < NWHEEL; i++) begin
            logic [IN_W-1:0] q_e;
            q_e = IN_W'(div_data[QUO_W].quo[i]);
            if (div_data[QUO_W].scaled) begin
                n_rpm[i] = div_data[QUO_W].w[i][IN_W-1] ? (IN_W'(0) - q_e) : q_e;
            end else begin
                n_rpm[i] = div_data[QUO_W].w[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_en) begin
            r_out_v <= div_valid[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && div_valid[QUO_W]) begin
            r_rpm    <= n_rpm;
            r_scaled <= div_data[QUO_W].scaled;
        end
    end

    assign o_valid           = r_out_v;
    assign o_front_right_rpm = r_rpm[0];
    assign o_front_left_rpm  = r_rpm[1];
    assign o_back_left_rpm   = r_rpm[2];
    assign o_back_right_rpm  = r_rpm[3];
    assign o_was_scaled      = r_scaled;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_comb begin
        n_inflight = r_inflight;
        if (in_acc && !out_acc) begin
            n_inflight = r_inflight + CNT_W'(1);
        end else if (!in_acc && out_acc) begin
            n_inflight = r_inflight - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output is free");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight <= CNT_W'(PIPE_DEPTH)) && ((r_inflight != '0) || !o_valid))
        else $error("request count out of range");

    a_scaled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_scaled) |->
            (o_front_right_rpm != 16'sh8000) && (o_front_left_rpm != 16'sh8000) &&
            (o_back_left_rpm != 16'sh8000) && (o_back_right_rpm != 16'sh8000))
        else $error("scaled wheel at negative full scale");

endmodule

// ===== src/mwm_front.sv =====
// Clamp, rotation product, wheel mix and magnitude split: four pipeline stages.
module mwm_front
    import mwm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_cmd               i_cmd,
    input  logic [LIM_W-1:0]   i_max_forward,
    input  logic [LIM_W-1:0]   i_max_sideways,
    input  logic [LIM_W-1:0]   i_max_turn,
    input  logic [RATIO_W-1:0] i_rotate_ratio,
    output logic               o_valid,
    input  logic               i_ready,
    output t_mag               o_mag
);

    function automatic logic signed [IN_W-1:0] clamp_mag(
        input logic signed [IN_W-1:0] v,
        input logic [LIM_W-1:0]       lim
    );
        logic signed [IN_W:0] v_e;
        logic signed [IN_W:0] lp;
        logic signed [IN_W:0] ln;
        logic signed [IN_W:0] res;
        v_e = {v[IN_W-1], v};
        lp  = $signed({2'b00, lim});
        ln  = -lp;
        if (v_e > lp) begin
            res = lp;
        end else if (v_e < ln) begin
            res = ln;
        end else begin
            res = v_e;
        end
        return res[IN_W-1:0];
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    t_cmd r_cmd1;
    t_cmd n_cmd1;

    logic [ROT_W-1:0] r_rot2;
    logic [ROT_W-1:0] n_rot2;
    logic [LIN_W-1:0] r_lin2 [NWHEEL];
    logic [LIN_W-1:0] n_lin2 [NWHEEL];
    logic [LIN_W-1:0] vx_e, vy_e;
    logic [ROT_W-1:0] vw_e, rr_e;

    logic [ROT_W-1:0] r_sum3 [NWHEEL];
    logic [ROT_W-1:0] n_sum3 [NWHEEL];

    t_mag r_mag4;
    t_mag n_mag4;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v4;
    assign o_mag   = r_mag4;

    always_comb begin
        n_cmd1.vx = clamp_mag(i_cmd.vx, i_max_forward);
        n_cmd1.vy = clamp_mag(i_cmd.vy, i_max_sideways);
        n_cmd1.vw = clamp_mag(i_cmd.vw, i_max_turn);
    end

    assign vx_e   = {{(LIN_W-IN_W){r_cmd1.vx[IN_W-1]}}, r_cmd1.vx};
    assign vy_e   = {{(LIN_W-IN_W){r_cmd1.vy[IN_W-1]}}, r_cmd1.vy};
    assign vw_e   = {{(ROT_W-IN_W){r_cmd1.vw[IN_W-1]}}, r_cmd1.vw};
    assign rr_e   = {{(ROT_W-RATIO_W){1'b0}}, i_rotate_ratio};
    assign n_rot2 = vw_e * rr_e;

    always_comb begin
        n_lin2[0] = LIN_W'(0) - vx_e - vy_e;
        n_lin2[1] = vx_e - vy_e;
        n_lin2[2] = vx_e + vy_e;
        n_lin2[3] = vy_e - vx_e;
    end

    always_comb begin
        for (int i = 0; i < NWHEEL; i++) begin
            n_sum3[i] = {{(ROT_W-LIN_W-FRAC_SH){r_lin2[i][LIN_W-1]}}, r_lin2[i],
                         {FRAC_SH{1'b0}}} + r_rot2;
        end
    end

    always_comb begin
        for (int i = 0; i < NWHEEL; i++) begin
            logic [ROT_W-1:0] flip;
            flip            = ROT_W'(0) - r_sum3[i];
            n_mag4.neg[i]   = r_sum3[i][ROT_W-1];
            n_mag4.mag[i]   = r_sum3[i][ROT_W-1] ? flip[MAG_W-1:0] : r_sum3[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_cmd1 <= n_cmd1;
        end
        if (en2 && r_v1) begin
            r_rot2 <= n_rot2;
            r_lin2 <= n_lin2;
        end
        if (en3 && r_v2) begin
            r_sum3 <= n_sum3;
        end
        if (en4 && r_v3) begin
            r_mag4 <= n_mag4;
        end
    end

endmodule

// ===== src/mwm_rpm.sv =====
// Rpm scaling in split partial products, saturation, peak search and divider setup.
module mwm_rpm
    import mwm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_mag               i_mag,
    input  logic [RATIO_W-1:0] i_rpm_ratio,
    input  logic [LIM_W-1:0]   i_max_wheel,
    output logic               o_valid,
    input  logic               i_ready,
    output t_div               o_div
);

    logic r_v5, r_v6, r_v7, r_v8;
    logic en5, en6, en7, en8;

    logic [PP_W-1:0]   r_hi5 [NWHEEL];
    logic [PP_W-1:0]   r_lo5 [NWHEEL];
    logic [PP_W-1:0]   n_hi5 [NWHEEL];
    logic [PP_W-1:0]   n_lo5 [NWHEEL];
    logic [NWHEEL-1:0] r_neg5, r_neg6, r_neg7;

    logic [RPM_W-1:0]  r_rpm6 [NWHEEL];
    logic [RPM_W-1:0]  n_rpm6 [NWHEEL];

    logic [ABS_W-1:0]  r_abs7 [NWHEEL];
    logic [ABS_W-1:0]  n_abs7 [NWHEEL];

    logic [ABS_W-1:0]  max01, max23, peak;
    t_div              r_div8;
    t_div              n_div8;

    assign en8     = !r_v8 || i_ready;
    assign en7     = !r_v7 || en8;
    assign en6     = !r_v6 || en7;
    assign en5     = !r_v5 || en6;
    assign o_ready = en5;
    assign o_valid = r_v8;
    assign o_div   = r_div8;

    always_comb begin
        for (int i = 0; i < NWHEEL; i++) begin
            n_hi5[i] = PP_W'(i_mag.mag[i][MAG_W-1:HALF_W]) * PP_W'(i_rpm_ratio);
            n_lo5[i] = PP_W'(i_mag.mag[i][HALF_W-1:0]) * PP_W'(i_rpm_ratio);
        end
    end

    always_comb begin
        for (int i = 0; i < NWHEEL; i++) begin
            logic [PP_W-1:0] acc;
            acc       = r_hi5[i] + PP_W'(r_lo5[i][PP_W-1:HALF_W]);
            n_rpm6[i] = acc[PP_W-1:HALF_W];
        end
    end

    always_comb begin
        for (int i = 0; i < NWHEEL; i++) begin
            if (r_neg6[i]) begin
                n_abs7[i] = (r_rpm6[i] > RPM_W'(32768)) ? ABS_W'(32768) : r_rpm6[i][ABS_W-1:0];
            end else begin
                n_abs7[i] = (r_rpm6[i] > RPM_W'(32767)) ? ABS_W'(32767) : r_rpm6[i][ABS_W-1:0];
            end
        end
    end

    assign max01 = (r_abs7[0] > r_abs7[1]) ? r_abs7[0] : r_abs7[1];
    assign max23 = (r_abs7[2] > r_abs7[3]) ? r_abs7[2] : r_abs7[3];
    assign peak  = (max01 > max23) ? max01 : max23;

    always_comb begin
        n_div8.peak   = peak;
        n_div8.scaled = peak > ABS_W'(i_max_wheel);
        for (int i = 0; i < NWHEEL; i++) begin
            n_div8.w[i]   = r_neg7[i] ? (ABS_W'(0) - r_abs7[i]) : r_abs7[i];
            n_div8.rem[i] = NUM_W'(r_abs7[i]) * NUM_W'(i_max_wheel);
            n_div8.quo[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            if (en5) begin
                r_v5 <= i_valid;
            end
            if (en6) begin
                r_v6 <= r_v5;
            end
            if (en7) begin
                r_v7 <= r_v6;
            end
            if (en8) begin
                r_v8 <= r_v7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5 && i_valid) begin
            r_hi5  <= n_hi5;
            r_lo5  <= n_lo5;
            r_neg5 <= i_mag.neg;
        end
        if (en6 && r_v5) begin
            r_rpm6 <= n_rpm6;
            r_neg6 <= r_neg5;
        end
        if (en7 && r_v6) begin
            r_abs7 <= n_abs7;
            r_neg7 <= r_neg6;
        end
        if (en8 && r_v7) begin
            r_div8 <= n_div8;
        end
    end

endmodule

// ===== src/mwm_div_step.sv =====
// One restoring division step, one quotient bit for all four wheels.
module mwm_div_step
    import mwm_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_div i_div,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_div
);

    logic             r_v;
    logic             en;
    t_div             r_div;
    t_div             n_div;
    logic [NUM_W-1:0] dsr;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_div   = r_div;
    assign dsr     = NUM_W'(i_div.peak) << BIT;

    always_comb begin
        n_div = i_div;
        for (int i = 0; i < NWHEEL; i++) begin
            if (i_div.rem[i] >= dsr) begin
                n_div.rem[i]      = i_div.rem[i] - dsr;
                n_div.quo[i][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_div <= n_div;
        end
    end

endmodule
